// ===== rtl/core/ambi_pkg.sv =====
package ambi_pkg;

	localparam int COORD_W    = 32;
	localparam int ANG_W      = 18;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_LOG2 = 2'd1;

	localparam logic [3:0] BLOCK_LOG2_RESET = 4'd8;
	localparam logic [3:0] BLOCK_LOG2_MAX   = 4'd12;

	// angles in 1/256 degree
	localparam int QUARTER_TURN = 23040;
	localparam int FULL_TURN    = 92160;

	localparam logic signed [COORD_W-1:0] ONE_Q30       = 32'sh4000_0000;
	localparam logic signed [COORD_W-1:0] INV_SQRT2_Q30 = 32'sd759250125;
	localparam int                        HALF_Q30      = 536870912;

	localparam int NUM_TRIG = 6;

	typedef logic signed [ANG_W-1:0]   angle_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [2:0]                trig_tag_t;

	localparam trig_tag_t TAG_SIN_EL = 3'd0;
	localparam trig_tag_t TAG_COS_EL = 3'd1;
	localparam trig_tag_t TAG_COS_L  = 3'd2;
	localparam trig_tag_t TAG_SIN_L  = 3'd3;
	localparam trig_tag_t TAG_COS_R  = 3'd4;
	localparam trig_tag_t TAG_SIN_R  = 3'd5;

	typedef struct packed {
		logic       stereo;
		logic [3:0] ramp_log2;
	} cfg_t;

	typedef struct packed {
		logic   block_start;
		angle_t neg_az_left;
		angle_t neg_az_right;
		angle_t elev;
	} ctl_item_t;

endpackage

// ===== rtl/core/ambi_front.sv =====
module ambi_front import ambi_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  cfg_t                          cfg,
	input  logic signed [SAMPLE_BITS-1:0] sample_left,
	input  logic signed [SAMPLE_BITS-1:0] sample_right,
	input  logic signed [15:0]            azimuth,
	input  logic signed [14:0]            elevation,
	input  logic signed [14:0]            spread_width,
	input  logic                          block_start,
	output ctl_item_t                     ctl,
	output logic signed [SAMPLE_BITS-1:0] left_smp,
	output logic signed [SAMPLE_BITS-1:0] right_smp
);

	angle_t az2, wd, el2, ang_l, ang_r;

	// work in 1/256 degree so that half the width is exact
	assign az2 = {{(ANG_W-17){azimuth[15]}}, azimuth, 1'b0};
	assign wd  = {{(ANG_W-15){spread_width[14]}}, spread_width};
	assign el2 = {{(ANG_W-16){elevation[14]}}, elevation, 1'b0};

	assign ang_l = cfg.stereo ? az2 - wd : az2;
	assign ang_r = az2 + wd;

	assign ctl.block_start  = block_start;
	assign ctl.neg_az_left  = -ang_l;
	assign ctl.neg_az_right = -ang_r;
	assign ctl.elev         = el2;

	assign left_smp  = sample_left;
	assign right_smp = cfg.stereo ? sample_right : '0;

endmodule

// ===== rtl/core/ambi_queue.sv =====
module ambi_queue #(
	parameter int WIDTH = 102
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             avail,
	output logic [WIDTH-1:0] pop_data
);

	localparam int DEPTH = 2;

	logic [WIDTH-1:0] entry_q [0:DEPTH-1];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'(DEPTH));
	assign avail    = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/core/ambi_sine.sv =====
module ambi_sine import ambi_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      issue,
	input  angle_t    angle,
	input  logic      use_cos,
	input  trig_tag_t tag_in,
	output logic      res_valid,
	output trig_tag_t res_tag,
	output coord_t    res_value
);

	localparam int U_W         = 17;
	localparam int OFF_W       = 15;
	localparam int NUM_W       = $clog2(QUARTER_TURN * SINE_TABLE_DEPTH + QUARTER_TURN / 2 + 1);
	localparam int RECIP_SHIFT = 44;
	localparam int PRODW       = NUM_W + 30;
	localparam int IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
	localparam logic [29:0] RECIP = 30'd763549742;

	function automatic logic [30:0] sine_entry(input int unsigned i);
		logic [63:0] x, x2, sum, t;
		x   = (64'd1686629713 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
		x2  = (x * x) >> 30;
		sum = x;
		t   = x;
		t = ((t * x2) >> 30) / 64'd6;   sum = sum - t;
		t = ((t * x2) >> 30) / 64'd20;  sum = sum + t;
		t = ((t * x2) >> 30) / 64'd42;  sum = sum - t;
		t = ((t * x2) >> 30) / 64'd72;  sum = sum + t;
		t = ((t * x2) >> 30) / 64'd110; sum = sum - t;
		t = ((t * x2) >> 30) / 64'd156; sum = sum + t;
		t = ((t * x2) >> 30) / 64'd210; sum = sum - t;
		t = ((t * x2) >> 30) / 64'd272; sum = sum + t;
		if (sum > 64'd1073741824) sum = 64'd1073741824;
		return sum[30:0];
	endfunction

	logic [30:0] sine_rom [0:SINE_TABLE_DEPTH];

	for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_rom
		assign sine_rom[i] = sine_entry(i);
	end

	logic signed [ANG_W:0] a_ext, a_wrap;
	logic [U_W-1:0]        r_full;
	logic [OFF_W-1:0]      off_c;
	logic                  neg_c;
	logic [PRODW-1:0]      recip_prod;

	logic [U_W-1:0]   u_s1;
	logic [OFF_W-1:0] off_s2;
	logic [NUM_W-1:0] num_s3;
	logic [IDX_W-1:0] idx_s4;
	logic [30:0]      rom_s5;
	coord_t           res_s6;
	logic [6:1]       vld;
	logic [6:2]       neg_q;
	trig_tag_t        tag_q [1:6];

	// wrap to one turn; the input range needs at most one correction
	always_comb begin
		a_ext = {angle[ANG_W-1], angle} + (use_cos ? (ANG_W+1)'(QUARTER_TURN) : '0);
		if (a_ext < 0) a_wrap = a_ext + (ANG_W+1)'(FULL_TURN);
		else if (a_ext >= (ANG_W+1)'(FULL_TURN)) a_wrap = a_ext - (ANG_W+1)'(FULL_TURN);
		else a_wrap = a_ext;
	end

	// fold into the first quadrant
	always_comb begin
		if (u_s1 < U_W'(QUARTER_TURN)) begin
			r_full = u_s1;
			off_c  = OFF_W'(r_full);
			neg_c  = 1'b0;
		end else if (u_s1 < U_W'(2 * QUARTER_TURN)) begin
			r_full = u_s1 - U_W'(QUARTER_TURN);
			off_c  = OFF_W'(U_W'(QUARTER_TURN) - r_full);
			neg_c  = 1'b0;
		end else if (u_s1 < U_W'(3 * QUARTER_TURN)) begin
			r_full = u_s1 - U_W'(2 * QUARTER_TURN);
			off_c  = OFF_W'(r_full);
			neg_c  = 1'b1;
		end else begin
			r_full = u_s1 - U_W'(3 * QUARTER_TURN);
			off_c  = OFF_W'(U_W'(QUARTER_TURN) - r_full);
			neg_c  = 1'b1;
		end
	end

	// round-to-nearest table index through a reciprocal of a quarter turn
	assign recip_prod = PRODW'(num_s3) * PRODW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld <= '0;
		else vld <= {vld[5:1], issue};
	end

	always_ff @(posedge clk) begin
		u_s1     <= U_W'(a_wrap);
		tag_q[1] <= tag_in;
		off_s2   <= off_c;
		neg_q[2] <= neg_c;
		tag_q[2] <= tag_q[1];
		num_s3   <= NUM_W'(off_s2) * NUM_W'(SINE_TABLE_DEPTH) + NUM_W'(QUARTER_TURN / 2);
		neg_q[3] <= neg_q[2];
		tag_q[3] <= tag_q[2];
		idx_s4   <= recip_prod[RECIP_SHIFT +: IDX_W];
		neg_q[4] <= neg_q[3];
		tag_q[4] <= tag_q[3];
		rom_s5   <= sine_rom[idx_s4];
		neg_q[5] <= neg_q[4];
		tag_q[5] <= tag_q[4];
		res_s6   <= neg_q[5] ? -coord_t'({1'b0, rom_s5}) : coord_t'({1'b0, rom_s5});
		neg_q[6] <= neg_q[5];
		tag_q[6] <= tag_q[5];
	end

	assign res_valid = vld[6];
	assign res_tag   = tag_q[6];
	assign res_value = res_s6;

endmodule

// ===== rtl/core/ambi_back.sv =====
module ambi_back import ambi_pkg::*; #(
	parameter int SAMPLE_BITS      = 24,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          q_avail,
	input  ctl_item_t                     q_ctl,
	input  logic signed [SAMPLE_BITS-1:0] q_left,
	input  logic signed [SAMPLE_BITS-1:0] q_right,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] w_out,
	output logic signed [SAMPLE_BITS-1:0] x_out,
	output logic signed [SAMPLE_BITS-1:0] y_out,
	output logic signed [SAMPLE_BITS-1:0] z_out
);

	localparam int SB     = SAMPLE_BITS;
	localparam int BW     = (SB + 1 > COORD_W) ? SB + 1 : COORD_W;
	localparam int PW     = COORD_W + BW;
	localparam int ACC_W  = PW + 1;
	localparam int SHW    = ACC_W + 1 - 30;
	localparam int STEP_W = COORD_W + 2;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TRIG = 3'd1;
	localparam logic [2:0] ST_PROD = 3'd2;
	localparam logic [2:0] ST_STEP = 3'd3;
	localparam logic [2:0] ST_ADV  = 3'd4;
	localparam logic [2:0] ST_MAC  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	localparam logic [2:0] PRD_XL = 3'd0;
	localparam logic [2:0] PRD_YL = 3'd1;
	localparam logic [2:0] PRD_XR = 3'd2;
	localparam logic [2:0] PRD_YR = 3'd3;

	localparam logic [2:0] MAC_W  = 3'd0;
	localparam logic [2:0] MAC_XL = 3'd1;
	localparam logic [2:0] MAC_XR = 3'd2;
	localparam logic [2:0] MAC_YL = 3'd3;
	localparam logic [2:0] MAC_YR = 3'd4;
	localparam logic [2:0] MAC_Z  = 3'd5;

	localparam logic signed [SB-1:0] SAT_HI = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SAT_LO = {1'b1, {(SB-1){1'b0}}};

	function automatic logic signed [SB-1:0] finish(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0] r;
		logic signed [SHW-1:0] s;
		r = {acc[ACC_W-1], acc} + (ACC_W+1)'(HALF_Q30);
		s = r[ACC_W:30];
		if (s > SHW'(SAT_HI)) return SAT_HI;
		if (s < SHW'(SAT_LO)) return SAT_LO;
		return s[SB-1:0];
	endfunction

	function automatic coord_t make_step(input coord_t target, input coord_t cur,
			input logic [3:0] n);
		logic signed [STEP_W-1:0] d, half, sh;
		d    = STEP_W'(target) - STEP_W'(cur);
		half = (n == 4'd0) ? '0 : (STEP_W'(1) <<< (n - 4'd1));
		sh   = (d + half) >>> n;
		if (sh > STEP_W'(coord_t'({1'b0, {(COORD_W-1){1'b1}}}))) return {1'b0, {(COORD_W-1){1'b1}}};
		if (sh < STEP_W'(coord_t'({1'b1, {(COORD_W-1){1'b0}}}))) return {1'b1, {(COORD_W-1){1'b0}}};
		return sh[COORD_W-1:0];
	endfunction

	function automatic coord_t advance(input coord_t c, input coord_t s);
		logic signed [COORD_W:0] t;
		t = {c[COORD_W-1], c} + {s[COORD_W-1], s};
		if (t[COORD_W] != t[COORD_W-1]) return {t[COORD_W], {(COORD_W-1){~t[COORD_W]}}};
		return t[COORD_W-1:0];
	endfunction

	logic [2:0] state_q, cnt_q;

	ctl_item_t              ctl_q;
	logic signed [SB-1:0]   left_q, right_q;
	logic signed [SB:0]     sum_q;
	coord_t sin_el_q, cos_el_q, cos_l_q, sin_l_q, cos_r_q, sin_r_q;
	coord_t tx_q, ty_q, rx_q, ry_q;
	coord_t left_x_coord_q, left_y_coord_q, height_coord_q, right_x_coord_q, right_y_coord_q;
	coord_t left_x_step_q, left_y_step_q, height_step_q, right_x_step_q, right_y_step_q;
	logic signed [ACC_W-1:0] acc_w_q, acc_x_q, acc_y_q, acc_z_q;
	logic signed [SB-1:0]    w_q, x_q, y_q, z_q;
	logic                    out_valid_q;

	logic            sine_go, sine_cos, sine_valid;
	angle_t          sine_angle;
	trig_tag_t       sine_tag;
	coord_t          sine_value;

	logic                    mul_go, prod_valid_s1;
	coord_t                  mul_a;
	logic signed [BW-1:0]    mul_b;
	logic signed [PW-1:0]    prod_s1, prod_rnd;
	logic [2:0]              prod_tag_s1;
	logic                    out_free, load_out;

	assign q_pop    = (state_q == ST_IDLE) && q_avail;
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == ST_FIN) && out_free;
	assign prod_rnd = prod_s1 + PW'(HALF_Q30);

	// table requests
	always_comb begin
		sine_go    = (state_q == ST_TRIG) && (cnt_q < 3'(NUM_TRIG));
		sine_angle = ctl_q.elev;
		sine_cos   = 1'b0;
		case (cnt_q)
			TAG_SIN_EL: begin sine_angle = ctl_q.elev;         sine_cos = 1'b0; end
			TAG_COS_EL: begin sine_angle = ctl_q.elev;         sine_cos = 1'b1; end
			TAG_COS_L:  begin sine_angle = ctl_q.neg_az_left;  sine_cos = 1'b1; end
			TAG_SIN_L:  begin sine_angle = ctl_q.neg_az_left;  sine_cos = 1'b0; end
			TAG_COS_R:  begin sine_angle = ctl_q.neg_az_right; sine_cos = 1'b1; end
			TAG_SIN_R:  begin sine_angle = ctl_q.neg_az_right; sine_cos = 1'b0; end
			default:    begin sine_angle = ctl_q.elev;         sine_cos = 1'b0; end
		endcase
	end

	ambi_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (sine_go),
		.angle     (sine_angle),
		.use_cos   (sine_cos),
		.tag_in    (cnt_q),
		.res_valid (sine_valid),
		.res_tag   (sine_tag),
		.res_value (sine_value)
	);

	// shared multiplier operands
	always_comb begin
		mul_go = 1'b0;
		mul_a  = cos_el_q;
		mul_b  = BW'(cos_l_q);
		case (state_q)
			ST_PROD: begin
				mul_go = (cnt_q <= PRD_YR);
				mul_a  = cos_el_q;
				case (cnt_q)
					PRD_XL:  mul_b = BW'(cos_l_q);
					PRD_YL:  mul_b = BW'(sin_l_q);
					PRD_XR:  mul_b = BW'(cos_r_q);
					default: mul_b = BW'(sin_r_q);
				endcase
			end
			ST_MAC: begin
				mul_go = (cnt_q <= MAC_Z);
				case (cnt_q)
					MAC_W:   begin mul_a = INV_SQRT2_Q30;   mul_b = BW'(sum_q);   end
					MAC_XL:  begin mul_a = left_x_coord_q;  mul_b = BW'(left_q);  end
					MAC_XR:  begin mul_a = right_x_coord_q; mul_b = BW'(right_q); end
					MAC_YL:  begin mul_a = left_y_coord_q;  mul_b = BW'(left_q);  end
					MAC_YR:  begin mul_a = right_y_coord_q; mul_b = BW'(right_q); end
					default: begin mul_a = height_coord_q;  mul_b = BW'(sum_q);   end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1     <= PW'(mul_a) * PW'(mul_b);
		prod_tag_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cnt_q           <= 3'd0;
			prod_valid_s1   <= 1'b0;
			out_valid_q     <= 1'b0;
			left_x_coord_q  <= ONE_Q30;
			left_y_coord_q  <= ONE_Q30;
			height_coord_q  <= ONE_Q30;
			right_x_coord_q <= ONE_Q30;
			right_y_coord_q <= ONE_Q30;
			left_x_step_q   <= '0;
			left_y_step_q   <= '0;
			height_step_q   <= '0;
			right_x_step_q  <= '0;
			right_y_step_q  <= '0;
		end else begin
			prod_valid_s1 <= mul_go;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= 3'd0;
					if (q_avail) state_q <= q_ctl.block_start ? ST_TRIG : ST_ADV;
				end
				ST_TRIG: begin
					if (sine_go) cnt_q <= cnt_q + 3'd1;
					if (sine_valid && sine_tag == TAG_SIN_R) begin
						state_q <= ST_PROD;
						cnt_q   <= 3'd0;
					end
				end
				ST_PROD: begin
					if (mul_go) cnt_q <= cnt_q + 3'd1;
					if (prod_valid_s1 && prod_tag_s1 == PRD_YR) state_q <= ST_STEP;
				end
				ST_STEP: begin
					left_x_step_q <= make_step(tx_q, left_x_coord_q, cfg.ramp_log2);
					left_y_step_q <= make_step(ty_q, left_y_coord_q, cfg.ramp_log2);
					height_step_q <= make_step(sin_el_q, height_coord_q, cfg.ramp_log2);
					if (cfg.stereo) begin
						right_x_step_q <= make_step(rx_q, right_x_coord_q, cfg.ramp_log2);
						right_y_step_q <= make_step(ry_q, right_y_coord_q, cfg.ramp_log2);
					end
					state_q <= ST_ADV;
				end
				ST_ADV: begin
					left_x_coord_q <= advance(left_x_coord_q, left_x_step_q);
					left_y_coord_q <= advance(left_y_coord_q, left_y_step_q);
					height_coord_q <= advance(height_coord_q, height_step_q);
					if (cfg.stereo) begin
						right_x_coord_q <= advance(right_x_coord_q, right_x_step_q);
						right_y_coord_q <= advance(right_y_coord_q, right_y_step_q);
					end
					cnt_q   <= 3'd0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (mul_go) cnt_q <= cnt_q + 3'd1;
					if (prod_valid_s1 && prod_tag_s1 == MAC_Z) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_q   <= q_ctl;
			left_q  <= q_left;
			right_q <= q_right;
			sum_q   <= (SB+1)'(q_left) + (SB+1)'(q_right);
		end
		if (state_q == ST_TRIG && sine_valid) begin
			case (sine_tag)
				TAG_SIN_EL: sin_el_q <= sine_value;
				TAG_COS_EL: cos_el_q <= sine_value;
				TAG_COS_L:  cos_l_q  <= sine_value;
				TAG_SIN_L:  sin_l_q  <= sine_value;
				TAG_COS_R:  cos_r_q  <= sine_value;
				default:    sin_r_q  <= sine_value;
			endcase
		end
		if (state_q == ST_PROD && prod_valid_s1) begin
			case (prod_tag_s1)
				PRD_XL:  tx_q <= prod_rnd[30 +: COORD_W];
				PRD_YL:  ty_q <= prod_rnd[30 +: COORD_W];
				PRD_XR:  rx_q <= prod_rnd[30 +: COORD_W];
				default: ry_q <= prod_rnd[30 +: COORD_W];
			endcase
		end
		if (state_q == ST_MAC && prod_valid_s1) begin
			case (prod_tag_s1)
				MAC_W:   acc_w_q <= ACC_W'(prod_s1);
				MAC_XL:  acc_x_q <= ACC_W'(prod_s1);
				MAC_XR:  acc_x_q <= acc_x_q + ACC_W'(prod_s1);
				MAC_YL:  acc_y_q <= ACC_W'(prod_s1);
				MAC_YR:  acc_y_q <= acc_y_q + ACC_W'(prod_s1);
				default: acc_z_q <= ACC_W'(prod_s1);
			endcase
		end
		if (load_out) begin
			w_q <= finish(acc_w_q);
			x_q <= finish(acc_x_q);
			y_q <= finish(acc_y_q);
			z_q <= finish(acc_z_q);
		end
	end

	assign out_valid = out_valid_q;
	assign w_out     = w_q;
	assign x_out     = x_q;
	assign y_out     = y_q;
	assign z_out     = z_q;

	a_sine_in_trig: assert property (@(posedge clk) disable iff (!arst_n)
		sine_valid |-> state_q == ST_TRIG)
		else $error("table result outside trig phase");

	a_prod_owner: assert property (@(posedge clk) disable iff (!arst_n)
		prod_valid_s1 |-> (state_q == ST_PROD || state_q == ST_MAC))
		else $error("product arrived with no consumer");

	a_right_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_ADV && cfg.stereo) |=> $stable(right_x_coord_q))
		else $error("right coordinate moved outside stereo advance");

	a_fin_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && out_stall) |=> state_q == ST_FIN)
		else $error("result dropped while output stalled");

endmodule

// ===== rtl/core/ambisonic_bformat_encoder.sv =====
// First-order B-format encoder. Plain sample, from the queue head to a valid result: pop,
// coordinate advance, six products through one shared multiplier, round.
// Block-start sample: adds six quarter-wave table lookups through a six-stage lookup pipeline,
// four direction products and the step update.
// A new transaction is taken only after the last one has finished; a two-entry queue decouples the input.
// Reset (arst_n, async, low) clears config to mono / ramp 2^8, coordinates to 1.0, steps to 0.
module ambisonic_bformat_encoder import ambi_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int SAMPLE_BITS      = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]          cfg_addr,
	input  logic [CFG_DATA_W-1:0]         cfg_wdata,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_left,
	input  logic signed [SAMPLE_BITS-1:0] sample_right,
	input  logic signed [15:0]            azimuth,
	input  logic signed [14:0]            elevation,
	input  logic signed [14:0]            spread_width,
	input  logic                          block_start,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] w_out,
	output logic signed [SAMPLE_BITS-1:0] x_out,
	output logic signed [SAMPLE_BITS-1:0] y_out,
	output logic signed [SAMPLE_BITS-1:0] z_out
);

	localparam int QW = $bits(ctl_item_t) + 2 * SAMPLE_BITS;

	logic       stereo_q;
	logic [3:0] block_log2_q;
	cfg_t       cfg;

	ctl_item_t                     fr_ctl, bk_ctl;
	logic signed [SAMPLE_BITS-1:0] fr_left, fr_right, bk_left, bk_right;
	logic                          q_full, q_push, q_pop, q_avail;
	logic [QW-1:0]                 q_out;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q     <= 1'b0;
			block_log2_q <= BLOCK_LOG2_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_STEREO_MODE:     stereo_q     <= cfg_wdata[0];
				REG_BLOCK_SIZE_LOG2: block_log2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Ramp lengths beyond the longest supported block act as the longest one.
	assign cfg.stereo    = stereo_q;
	assign cfg.ramp_log2 = (block_log2_q > BLOCK_LOG2_MAX) ? BLOCK_LOG2_MAX : block_log2_q;

	// Front: form the source angles and mask the right sample in mono.
	ambi_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.cfg          (cfg),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.azimuth      (azimuth),
		.elevation    (elevation),
		.spread_width (spread_width),
		.block_start  (block_start),
		.ctl          (fr_ctl),
		.left_smp     (fr_left),
		.right_smp    (fr_right)
	);

	// Stall the input only when the queue is full.
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	ambi_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({fr_ctl, fr_left, fr_right}),
		.full      (q_full),
		.pop       (q_pop),
		.avail     (q_avail),
		.pop_data  (q_out)
	);

	assign bk_ctl   = q_out[QW-1 -: $bits(ctl_item_t)];
	assign bk_left  = q_out[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
	assign bk_right = q_out[SAMPLE_BITS-1:0];

	// Back: direction update, coordinate glide and channel products.
	ambi_back #(
		.SAMPLE_BITS      (SAMPLE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_avail   (q_avail),
		.q_ctl     (bk_ctl),
		.q_left    (bk_left),
		.q_right   (bk_right),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.w_out     (w_out),
		.x_out     (x_out),
		.y_out     (y_out),
		.z_out     (z_out)
	);

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
	import ambi_pkg::*;

	localparam int SMP_W = 24;
	localparam int TAB_DEPTH = 1024;
	// index with no register behind it; a write there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic signed [SMP_W-1:0] left;
		logic signed [SMP_W-1:0] right;
		logic signed [15:0]      az;
		logic signed [14:0]      el;
		logic signed [14:0]      width;
		logic                    start;
	} sample_item_t;

	typedef struct {
		logic signed [SMP_W-1:0] w;
		logic signed [SMP_W-1:0] x;
		logic signed [SMP_W-1:0] y;
		logic signed [SMP_W-1:0] z;
	} bformat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SMP_W-1:0] sample_left = '0, sample_right = '0;
	logic signed [15:0] azimuth = '0;
	logic signed [14:0] elevation = '0, spread_width = '0;
	logic block_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SMP_W-1:0] w_out, x_out, y_out, z_out;

	ambisonic_bformat_encoder #(.SINE_TABLE_DEPTH(TAB_DEPTH), .SAMPLE_BITS(SMP_W)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_left(sample_left), .sample_right(sample_right),
		.azimuth(azimuth), .elevation(elevation), .spread_width(spread_width),
		.block_start(block_start),
		.out_valid(out_valid), .out_stall(out_stall),
		.w_out(w_out), .x_out(x_out), .y_out(y_out), .z_out(z_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Encoder prediction: own copy of config, coordinates and steps
	// ---------------------------------------------------------------
	longint sine_q30 [0:TAB_DEPTH];
	logic   pan_stereo;
	logic [3:0] pan_log2;
	longint lx_pos, ly_pos, hz_pos, rx_pos, ry_pos;
	longint lx_inc, ly_inc, hz_inc, rx_inc, ry_inc;

	sample_item_t pend_q[$];
	bformat_t     bformat_q[$];
	int  mismatches = 0;
	bit  quiet = 0;

	function automatic void build_sine();
		longint unsigned x, x2, sum, t;
		for (int i = 0; i <= TAB_DEPTH; i++) begin
			x = (64'd1686629713 * i) / TAB_DEPTH;
			x2 = (x * x) >> 30;
			sum = x;
			t = x;
			for (int k = 1; k <= 8; k++) begin
				t = ((t * x2) >> 30) / ((2 * k) * (2 * k + 1));
				if (k & 1) sum = sum - t;
				else sum = sum + t;
			end
			if (sum > 64'd1073741824) sum = 64'd1073741824;
			sine_q30[i] = longint'(sum);
		end
	endfunction

	function automatic longint clamp_bits(longint v, int bits);
		longint hi, lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint quarter_sine(int r);
		longint idx;
		idx = (longint'(r) * TAB_DEPTH + 11520) / 23040;
		if (idx > TAB_DEPTH) idx = TAB_DEPTH;
		return sine_q30[idx];
	endfunction

	// angle in 1/256 degree; wraps any value around the circle
	function automatic longint sine_of(int ang);
		int u, q, r;
		longint mag;
		u = ang % FULL_TURN;
		if (u < 0) u += FULL_TURN;
		q = u / QUARTER_TURN;
		r = u % QUARTER_TURN;
		mag = (q & 1) ? quarter_sine(QUARTER_TURN - r) : quarter_sine(r);
		return q >= 2 ? -mag : mag;
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		return (a * b + HALF_Q30) >>> 30;
	endfunction

	function automatic longint ramp_step(longint target, longint cur, int n);
		longint diff;
		diff = target - cur;
		if (n == 0) return clamp_bits(diff, 32);
		return clamp_bits((diff + (longint'(1) <<< (n - 1))) >>> n, 32);
	endfunction

	function automatic logic signed [SMP_W-1:0] round_out(longint acc);
		return SMP_W'(clamp_bits((acc + HALF_Q30) >>> 30, SMP_W));
	endfunction

	function automatic bformat_t encode_sample(sample_item_t it);
		longint l, r, ce, tx, ty, tz;
		int az2, el2, wd, n, ang;
		bformat_t res;
		l = longint'(it.left);
		r = longint'(it.right);
		az2 = int'(it.az) * 2;
		el2 = int'(it.el) * 2;
		wd = int'(it.width);
		n = pan_log2 > BLOCK_LOG2_MAX ? int'(BLOCK_LOG2_MAX) : int'(pan_log2);
		if (it.start) begin
			ce = sine_of(el2 + QUARTER_TURN);
			tz = sine_of(el2);
			ang = pan_stereo ? az2 - wd : az2;
			tx = q30_mul(ce, sine_of(-ang + QUARTER_TURN));
			ty = q30_mul(ce, sine_of(-ang));
			lx_inc = ramp_step(tx, lx_pos, n);
			ly_inc = ramp_step(ty, ly_pos, n);
			hz_inc = ramp_step(tz, hz_pos, n);
			if (pan_stereo) begin
				ang = az2 + wd;
				tx = q30_mul(ce, sine_of(-ang + QUARTER_TURN));
				ty = q30_mul(ce, sine_of(-ang));
				rx_inc = ramp_step(tx, rx_pos, n);
				ry_inc = ramp_step(ty, ry_pos, n);
			end
		end
		// advance first, then mix; coordinates saturate on a missed block start
		lx_pos = clamp_bits(lx_pos + lx_inc, 32);
		ly_pos = clamp_bits(ly_pos + ly_inc, 32);
		hz_pos = clamp_bits(hz_pos + hz_inc, 32);
		if (pan_stereo) begin
			rx_pos = clamp_bits(rx_pos + rx_inc, 32);
			ry_pos = clamp_bits(ry_pos + ry_inc, 32);
		end else begin
			r = 0;
		end
		res.w = round_out(longint'(INV_SQRT2_Q30) * (l + r));
		res.x = round_out(lx_pos * l + rx_pos * r);
		res.y = round_out(ly_pos * l + ry_pos * r);
		res.z = round_out(hz_pos * (l + r));
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Driver: one transaction per free slot, random idle bursts
	// ---------------------------------------------------------------
	sample_item_t cur_item;
	int in_gap = 0;

	always @(posedge clk) begin
		bit slot_free;
		if (arst_n) begin
			if (in_valid && !in_stall)
				bformat_q.insert(bformat_q.size(), encode_sample(cur_item));
			slot_free = !in_valid || !in_stall;
			if (slot_free) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pend_q.size() > 0) begin
					cur_item = pend_q.pop_front();
					sample_left <= cur_item.left;
					sample_right <= cur_item.right;
					azimuth <= cur_item.az;
					elevation <= cur_item.el;
					spread_width <= cur_item.width;
					block_start <= cur_item.start;
					in_valid <= 1'b1;
					// idle after this one, so gaps land on every phase of the work
					if (!quiet && $urandom_range(0, 3) == 0) in_gap <= $urandom_range(1, 7);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: random stall bursts, compare against oldest expectation
	// ---------------------------------------------------------------
	int out_hold = 0;

	always @(posedge clk) begin
		bformat_t exp_b;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (bformat_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result w=%0d x=%0d y=%0d z=%0d",
							w_out, x_out, y_out, z_out);
				end else begin
					exp_b = bformat_q.pop_front();
					if (w_out !== exp_b.w || x_out !== exp_b.x ||
							y_out !== exp_b.y || z_out !== exp_b.z) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
								exp_b.w, exp_b.x, exp_b.y, exp_b.z,
								w_out, x_out, y_out, z_out);
					end
				end
			end
			if (out_hold > 0) begin
				out_hold <= out_hold - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_hold <= $urandom_range(0, 6);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == REG_STEREO_MODE) pan_stereo = val[0];
		else if (idx == REG_BLOCK_SIZE_LOG2) pan_log2 = val;
	endtask

	function automatic sample_item_t make_item(int l, int r, int az, int el, int wd, bit st);
		sample_item_t it;
		it.left = SMP_W'(l);
		it.right = SMP_W'(r);
		it.az = 16'(az);
		it.el = 15'(el);
		it.width = 15'(wd);
		it.start = st;
		return it;
	endfunction

	// append one item to the tail of the pending list
	task automatic add_pending(sample_item_t it);
		pend_q.insert(pend_q.size(), it);
	endtask

	function automatic int rand_sample();
		case ($urandom_range(0, 5))
			0: return -8388608;
			1: return 8388607;
			2: return $urandom_range(0, 2000) - 1000;
			default: return int'($urandom_range(0, 16777215)) - 8388608;
		endcase
	endfunction

	function automatic sample_item_t rand_item();
		int az, el, wd;
		// mostly in range; sometimes the whole field to hit wrap-around
		az = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535)) - 32768
			: int'($urandom_range(0, 46080)) - 23040;
		el = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 32767)) - 16384
			: int'($urandom_range(0, 23040)) - 11520;
		wd = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 32767)) - 16384
			: int'($urandom_range(0, 23040)) - 11520;
		return make_item(rand_sample(), rand_sample(), az, el, wd, $urandom_range(0, 7) == 0);
	endfunction

	task automatic push_directed();
		add_pending(make_item(0, 0, 0, 0, 0, 1));
		add_pending(make_item(8388607, 8388607, 0, 0, 0, 0));
		add_pending(make_item(-8388608, -8388608, 0, 0, 0, 0));
		add_pending(make_item(8388607, -8388608, 23040, 11520, 11520, 1));
		add_pending(make_item(-8388608, 8388607, -23040, -11520, -11520, 1));
		add_pending(make_item(4194304, -4194304, 11520, 5760, 2880, 1));
		add_pending(make_item(8388607, 8388607, 32767, 16383, 16383, 1));
		add_pending(make_item(-8388608, -8388608, -32768, -16384, -16384, 1));
		// no block start: steps keep being added
		for (int i = 0; i < 5; i++)
			add_pending(make_item(8388607, -8388608, 0, 0, 0, 0));
	endtask

	task automatic wait_drained();
		while (pend_q.size() != 0 || bformat_q.size() != 0 || in_valid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		// stereo, ramp log2 per phase; extremes and the oversized length included
		bit         ph_stereo [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
		logic [3:0] ph_log2   [6] = '{4'd8, 4'd0, 4'd12, 4'd15, 4'd3, 4'd1};
		build_sine();
		pan_stereo = 1'b0;
		pan_log2 = BLOCK_LOG2_RESET;
		lx_pos = ONE_Q30; ly_pos = ONE_Q30; hz_pos = ONE_Q30;
		rx_pos = ONE_Q30; ry_pos = ONE_Q30;
		lx_inc = 0; ly_inc = 0; hz_inc = 0; rx_inc = 0; ry_inc = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				write_reg(REG_UNMAPPED, 4'($urandom_range(0, 15)));
				write_reg(REG_STEREO_MODE, {3'($urandom_range(0, 7)), ph_stereo[ph]});
				write_reg(REG_BLOCK_SIZE_LOG2, ph_log2[ph]);
				cfg_wr_en <= 1'b0;
			end
			// no idling on the last phase
			if (ph == 5) quiet = 1;
			if (ph < 2) push_directed();
			for (int i = 0; i < 125; i++) add_pending(rand_item());
			wait_drained();
		end

		if (mismatches == 0 && bformat_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
